// ----- hw/rtl/nhps_pkg.sv -----
// shared widths, types, constants and helpers for the neo-hookean stress pipeline
`default_nettype none

package nhps_pkg;

  // field widths
  localparam int W_IN       = 32;
  localparam int W_OUT      = 64;
  localparam int W_MOD      = 48;
  localparam int W_ALPHA    = 31;
  localparam int W_CFG_IDX  = 3;
  localparam int W_CFG_DATA = 48;

  // limb split for the wide products: low limbs unsigned, top limb signed
  localparam int W_LIMB  = 32;
  localparam int W_LPROD = 2 * (W_LIMB + 1);

  // internal value widths, each bounds the exact value it carries
  localparam int W_PROD = 2 * W_IN;             // cofactor product, Q.48
  localparam int W_COF  = W_PROD + 1;           // cofactor entry, Q.48
  localparam int W_DPP  = W_IN + W_LIMB + 1;    // determinant limb product
  localparam int W_ROW  = W_IN + W_COF;         // one determinant term, Q.72
  localparam int W_D    = 100;                  // determinant minus offset, Q.72
  localparam int W_FACQ = W_MOD + W_LIMB + 2;   // lambda times one d limb
  localparam int W_FAC  = 150;                  // scale factor, Q.88
  localparam int W_TERM = 216;                  // stress entry before rounding, Q.136

  // fixed-point alignment
  localparam int ALPHA_SHIFT = 48;              // Q.24 -> Q.72
  localparam int MIX_SHIFT   = 72;              // Q.16 -> Q.88
  localparam int MU_SHIFT    = 96;              // Q.16 -> Q.112
  localparam int RND_SHIFT   = 112;             // Q.136 -> Q.24
  localparam int W_RND       = W_TERM - RND_SHIFT;

  localparam logic [W_TERM-1:0] RND_HALF = W_TERM'(1) << (RND_SHIFT - 1);

  // pipeline layout
  localparam int N_STAGE = 12;
  localparam int ST_COF  = 2;                   // cofactor ready after this stage
  localparam int ST_FAC  = 8;                   // scale factor ready after this stage

  localparam logic [W_ALPHA-1:0] ALPHA_RESET = W_ALPHA'(24'hFFFFFF) + W_ALPHA'(1);

  // register indexes on the configuration port
  typedef enum logic [W_CFG_IDX-1:0] {
    CFG_LAMBDA = 3'd0,
    CFG_MU     = 3'd1,
    CFG_ALPHA  = 3'd2,
    CFG_MIXED  = 3'd3
  } cfg_idx_t;

  typedef logic signed [W_IN-1:0]    def_t;
  typedef logic signed [W_COF-1:0]   cof_t;
  typedef logic signed [W_FAC-1:0]   fac_t;
  typedef logic signed [W_OUT-1:0]   stress_t;
  typedef logic signed [W_LIMB:0]    limb_t;
  typedef logic signed [W_LPROD-1:0] lprod_t;
  typedef logic signed [W_TERM-1:0]  term_t;
  typedef logic [W_MOD-1:0]          mod_t;
  typedef logic [W_ALPHA-1:0]        alpha_t;

  localparam stress_t STRESS_MAX = {1'b0, {(W_OUT-1){1'b1}}};
  localparam stress_t STRESS_MIN = {1'b1, {(W_OUT-1){1'b0}}};

  // stage load enables, one group per pipeline section
  typedef struct packed {
    logic ld_prod;
    logic ld_cof;
  } cof_en_t;

  typedef struct packed {
    logic ld_dpp;
    logic ld_row;
    logic ld_d;
    logic ld_fpp;
    logic ld_fq;
    logic ld_fac;
  } fac_en_t;

  typedef struct packed {
    logic ld_pp;
    logic ld_part;
    logic ld_sum;
    logic ld_out;
  } lane_en_t;

  // unsigned low limb as a signed multiplier operand
  function automatic limb_t limb_lo(input logic [W_LIMB-1:0] x);
    limb_lo = {1'b0, x};
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/neo_hookean_piola_stress.sv -----
// top level: first piola stress of a stable neo-hookean material, one gradient per beat
//
//   channel  dir  handshake              payload
//   in       in   in_valid / in_ready    def_00 .. def_22 (Q8.24)
//   out      out  out_valid / out_ready  stress_00 .. stress_22 (Q40.24), saturated
//   cfg      in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one beat per cycle in and out while the output is not stalled; a result passes
// through the 12-stage pipeline of 33x33 limb products and their aligned sums
// each stage has a valid bit; a stage loads when it is empty or the next one loads,
// so bubbles are squeezed out and a stalled output holds only the full stages behind it
// synchronous reset clears the valid bits and loads the register defaults
// cfg_ready is always high; the user must write registers only while the pipeline
// is empty, as the block itself does not enforce it
`default_nettype none

module neo_hookean_piola_stress
  import nhps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,

  input  logic                  in_valid,
  output logic                  in_ready,
  input  def_t                  def_00,
  input  def_t                  def_10,
  input  def_t                  def_20,
  input  def_t                  def_01,
  input  def_t                  def_11,
  input  def_t                  def_21,
  input  def_t                  def_02,
  input  def_t                  def_12,
  input  def_t                  def_22,

  output logic                  out_valid,
  input  logic                  out_ready,
  output stress_t               stress_00,
  output stress_t               stress_10,
  output stress_t               stress_20,
  output stress_t               stress_01,
  output stress_t               stress_11,
  output stress_t               stress_21,
  output stress_t               stress_02,
  output stress_t               stress_12,
  output stress_t               stress_22,
  output logic                  saturated,

  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [W_CFG_IDX-1:0]  cfg_index,
  input  logic [W_CFG_DATA-1:0] cfg_data
);

  mod_t                 lame_lambda;
  mod_t                 shear_mu;
  alpha_t               rest_alpha;
  logic                 mixed_mode;

  logic [N_STAGE:1]     v;
  logic [N_STAGE+1:1]   en;
  cof_en_t              cof_en;
  fac_en_t              fac_en;
  lane_en_t             lane_en;

  def_t                 col_in [3][3];
  def_t                 col_d  [1:ST_FAC][3][3];
  cof_t                 cof_s  [3][3];
  cof_t                 cof_d  [ST_COF+1:ST_FAC][3][3];
  fac_t                 fac;
  stress_t              lane_stress [3][3];
  logic [8:0]           lane_sat;
  logic [8:0]           sat_bad;
  logic                 in_acc;
  logic                 out_acc;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lame_lambda <= '0;
      shear_mu    <= '0;
      rest_alpha  <= ALPHA_RESET;
      mixed_mode  <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_LAMBDA: lame_lambda <= cfg_data[W_MOD-1:0];
        CFG_MU:     shear_mu    <= cfg_data[W_MOD-1:0];
        CFG_ALPHA:  rest_alpha  <= cfg_data[W_ALPHA-1:0];
        CFG_MIXED:  mixed_mode  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // stage enables ripple back from the output
  assign en[N_STAGE+1] = out_ready;
  for (genvar k = 1; k <= N_STAGE; k++) begin : g_en
    assign en[k] = !v[k] || en[k+1];
  end

  assign in_ready  = en[1];
  assign out_valid = v[N_STAGE];
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) begin
        v[1] <= in_valid;
      end
      for (int k = 2; k <= N_STAGE; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  always_comb begin
    cof_en.ld_prod  = en[1];
    cof_en.ld_cof   = en[2];
    fac_en.ld_dpp   = en[3];
    fac_en.ld_row   = en[4];
    fac_en.ld_d     = en[5];
    fac_en.ld_fpp   = en[6];
    fac_en.ld_fq    = en[7];
    fac_en.ld_fac   = en[8];
    lane_en.ld_pp   = en[9];
    lane_en.ld_part = en[10];
    lane_en.ld_sum  = en[11];
    lane_en.ld_out  = en[12];
  end

  // gradient as columns
  always_comb begin
    col_in[0][0] = def_00;
    col_in[0][1] = def_10;
    col_in[0][2] = def_20;
    col_in[1][0] = def_01;
    col_in[1][1] = def_11;
    col_in[1][2] = def_21;
    col_in[2][0] = def_02;
    col_in[2][1] = def_12;
    col_in[2][2] = def_22;
  end

  // gradient and cofactor delay lines up to the stress lanes
  always_ff @(posedge clk) begin
    if (en[1]) begin
      col_d[1] <= col_in;
    end
    for (int k = 2; k <= ST_FAC; k++) begin
      if (en[k]) begin
        col_d[k] <= col_d[k-1];
      end
    end
    if (en[ST_COF+1]) begin
      cof_d[ST_COF+1] <= cof_s;
    end
    for (int k = ST_COF + 2; k <= ST_FAC; k++) begin
      if (en[k]) begin
        cof_d[k] <= cof_d[k-1];
      end
    end
  end

  nhps_cofactor u_cofactor (
    .clk (clk),
    .en  (cof_en),
    .col (col_in),
    .cof (cof_s)
  );

  nhps_factor u_factor (
    .clk         (clk),
    .en          (fac_en),
    .col0        (col_d[ST_COF][0]),
    .cof0        (cof_s[0]),
    .lame_lambda (lame_lambda),
    .shear_mu    (shear_mu),
    .rest_alpha  (rest_alpha),
    .mixed_mode  (mixed_mode),
    .fac         (fac)
  );

  // nine stress lanes
  for (genvar c = 0; c < 3; c++) begin : g_lc
    for (genvar r = 0; r < 3; r++) begin : g_lr
      nhps_lane u_lane (
        .clk    (clk),
        .en     (lane_en),
        .fac    (fac),
        .cof    (cof_d[ST_FAC][c][r]),
        .col    (col_d[ST_FAC][c][r]),
        .mu     (shear_mu),
        .stress (lane_stress[c][r]),
        .sat    (lane_sat[3*c + r])
      );

      assign sat_bad[3*c + r] = lane_sat[3*c + r]
                                && (lane_stress[c][r] != STRESS_MAX)
                                && (lane_stress[c][r] != STRESS_MIN);
    end
  end

  // result beat
  assign stress_00 = lane_stress[0][0];
  assign stress_10 = lane_stress[0][1];
  assign stress_20 = lane_stress[0][2];
  assign stress_01 = lane_stress[1][0];
  assign stress_11 = lane_stress[1][1];
  assign stress_21 = lane_stress[1][2];
  assign stress_02 = lane_stress[2][0];
  assign stress_12 = lane_stress[2][1];
  assign stress_22 = lane_stress[2][2];
  assign saturated = |lane_sat;

  // items in flight change only by beats taken and delivered
  a_occupancy: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> ($countones(v) ==
      $past($countones(v)) + int'($past(in_acc)) - int'($past(out_acc))))
    else $error("pipeline occupancy does not match accepted and delivered beats");

  // input side stalls only when every stage holds an item
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (&v))
    else $error("input stalled while the pipeline has a free stage");

  // a clipped entry holds one of the two limits
  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(|sat_bad))
    else $error("saturated entry is not at a limit value");

endmodule

`default_nettype wire

// ----- hw/rtl/nhps_cofactor.sv -----
// cofactor matrix of the deformation gradient, two register stages
`default_nettype none

module nhps_cofactor
  import nhps_pkg::*;
(
  input  logic    clk,
  input  cof_en_t en,
  input  def_t    col [3][3],
  output cof_t    cof [3][3]
);

  logic signed [W_PROD-1:0] pa [3][3];
  logic signed [W_PROD-1:0] pb [3][3];

  // cofactor column c is the cross product of the two other columns
  for (genvar c = 0; c < 3; c++) begin : g_col
    for (genvar r = 0; r < 3; r++) begin : g_row
      localparam int CA = (c + 1) % 3;
      localparam int CB = (c + 2) % 3;
      localparam int R1 = (r + 1) % 3;
      localparam int R2 = (r + 2) % 3;

      // stage 1: the two products of each entry
      always_ff @(posedge clk) begin
        if (en.ld_prod) begin
          pa[c][r] <= col[CA][R1] * col[CB][R2];
          pb[c][r] <= col[CA][R2] * col[CB][R1];
        end
      end

      // stage 2: exact difference
      always_ff @(posedge clk) begin
        if (en.ld_cof) begin
          cof[c][r] <= W_COF'(pa[c][r]) - W_COF'(pb[c][r]);
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/nhps_factor.sv -----
// scale factor: lambda times (determinant minus rest offset), or minus mu
`default_nettype none

module nhps_factor
  import nhps_pkg::*;
(
  input  logic    clk,
  input  fac_en_t en,
  input  def_t    col0 [3],
  input  cof_t    cof0 [3],
  input  mod_t    lame_lambda,
  input  mod_t    shear_mu,
  input  alpha_t  rest_alpha,
  input  logic    mixed_mode,
  output fac_t    fac
);

  logic signed [W_DPP-1:0]  dpp_lo [3];
  logic signed [W_DPP-1:0]  dpp_hi [3];
  logic signed [W_ROW-1:0]  row    [3];
  logic signed [W_D-1:0]    d;
  limb_t                    la     [2];
  limb_t                    lb     [4];
  lprod_t                   fpp    [2][4];
  logic signed [W_FACQ-1:0] fq     [4];

  // stage 3: first column times first cofactor column, split by cofactor limb
  for (genvar r = 0; r < 3; r++) begin : g_det
    always_ff @(posedge clk) begin
      if (en.ld_dpp) begin
        dpp_lo[r] <= col0[r] * limb_lo(cof0[r][W_LIMB-1:0]);
        dpp_hi[r] <= col0[r] * $signed(cof0[r][W_COF-1:W_LIMB]);
      end
    end

    // stage 4: recombine each determinant term
    always_ff @(posedge clk) begin
      if (en.ld_row) begin
        row[r] <= (W_ROW'(dpp_hi[r]) <<< W_LIMB) + W_ROW'(dpp_lo[r]);
      end
    end
  end

  // stage 5: determinant minus the rest offset, Q.72
  always_ff @(posedge clk) begin
    if (en.ld_d) begin
      d <= W_D'(row[0]) + W_D'(row[1]) + W_D'(row[2])
           - (W_D'(rest_alpha) << ALPHA_SHIFT);
    end
  end

  // limb operands for lambda times d
  always_comb begin
    la[0] = limb_lo(lame_lambda[W_LIMB-1:0]);
    la[1] = limb_t'(lame_lambda[W_MOD-1:W_LIMB]);
    lb[0] = limb_lo(d[W_LIMB-1:0]);
    lb[1] = limb_lo(d[2*W_LIMB-1:W_LIMB]);
    lb[2] = limb_lo(d[3*W_LIMB-1:2*W_LIMB]);
    lb[3] = limb_t'($signed(d[W_D-1:3*W_LIMB]));
  end

  // stage 6: limb partial products
  for (genvar i = 0; i < 2; i++) begin : g_fa
    for (genvar j = 0; j < 4; j++) begin : g_fb
      always_ff @(posedge clk) begin
        if (en.ld_fpp) begin
          fpp[i][j] <= la[i] * lb[j];
        end
      end
    end
  end

  // stage 7: lambda times each d limb
  for (genvar j = 0; j < 4; j++) begin : g_fq
    always_ff @(posedge clk) begin
      if (en.ld_fq) begin
        fq[j] <= W_FACQ'(fpp[0][j]) + (W_FACQ'(fpp[1][j]) <<< W_LIMB);
      end
    end
  end

  // stage 8: full factor, or minus mu in mixed mode, Q.88
  always_ff @(posedge clk) begin
    if (en.ld_fac) begin
      if (mixed_mode) begin
        fac <= -(W_FAC'(shear_mu) << MIX_SHIFT);
      end else begin
        fac <= W_FAC'(fq[0])
               + (W_FAC'(fq[1]) <<< W_LIMB)
               + (W_FAC'(fq[2]) <<< (2 * W_LIMB))
               + (W_FAC'(fq[3]) <<< (3 * W_LIMB));
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/nhps_lane.sv -----
// one stress entry: factor times cofactor plus mu times gradient, round, saturate
`default_nettype none

module nhps_lane
  import nhps_pkg::*;
(
  input  logic     clk,
  input  lane_en_t en,
  input  fac_t     fac,
  input  cof_t     cof,
  input  def_t     col,
  input  mod_t     mu,
  output stress_t  stress,
  output logic     sat
);

  localparam int FAC_LIMBS = 5;
  localparam int COF_LIMBS = 2;
  localparam int MU_LIMBS  = 2;
  localparam int FAC_PP    = FAC_LIMBS * COF_LIMBS;
  localparam int N_PP      = FAC_PP + MU_LIMBS;
  localparam int N_PART    = 4;
  localparam int PP_GROUP  = N_PP / N_PART;

  // bit offset of partial product k
  function automatic int pp_shift(input int k);
    if (k < FAC_PP) begin
      pp_shift = W_LIMB * ((k >> 1) + (k & 1));
    end else begin
      pp_shift = MU_SHIFT + W_LIMB * (k - FAC_PP);
    end
  endfunction

  limb_t                   fl   [FAC_LIMBS];
  limb_t                   cl   [COF_LIMBS];
  limb_t                   ml   [MU_LIMBS];
  limb_t                   cx;
  lprod_t                  pp   [N_PP];
  term_t                   part [N_PART];
  term_t                   total;
  logic signed [W_RND-1:0] rnd;
  logic                    fits;

  // limb operands
  always_comb begin
    for (int i = 0; i < FAC_LIMBS - 1; i++) begin
      fl[i] = limb_lo(fac[W_LIMB*i +: W_LIMB]);
    end
    fl[FAC_LIMBS-1] = limb_t'($signed(fac[W_FAC-1:W_LIMB*(FAC_LIMBS-1)]));
    cl[0] = limb_lo(cof[W_LIMB-1:0]);
    cl[1] = limb_t'($signed(cof[W_COF-1:W_LIMB]));
    ml[0] = limb_lo(mu[W_LIMB-1:0]);
    ml[1] = limb_t'(mu[W_MOD-1:W_LIMB]);
    cx    = limb_t'(col);
  end

  // stage 9: factor limbs times cofactor limbs
  for (genvar i = 0; i < FAC_LIMBS; i++) begin : g_fl
    for (genvar j = 0; j < COF_LIMBS; j++) begin : g_cl
      always_ff @(posedge clk) begin
        if (en.ld_pp) begin
          pp[COF_LIMBS*i + j] <= fl[i] * cl[j];
        end
      end
    end
  end

  // stage 9: mu limbs times the gradient entry
  for (genvar m = 0; m < MU_LIMBS; m++) begin : g_ml
    always_ff @(posedge clk) begin
      if (en.ld_pp) begin
        pp[FAC_PP + m] <= ml[m] * cx;
      end
    end
  end

  // stage 10: aligned partial sums, three products each
  for (genvar g = 0; g < N_PART; g++) begin : g_part
    localparam int K0 = PP_GROUP * g;
    always_ff @(posedge clk) begin
      if (en.ld_part) begin
        part[g] <= (term_t'(pp[K0])     <<< pp_shift(K0))
                 + (term_t'(pp[K0 + 1]) <<< pp_shift(K0 + 1))
                 + (term_t'(pp[K0 + 2]) <<< pp_shift(K0 + 2));
      end
    end
  end

  // stage 11: full Q.136 value plus half of the last kept place
  always_ff @(posedge clk) begin
    if (en.ld_sum) begin
      total <= part[0] + part[1] + part[2] + part[3] + RND_HALF;
    end
  end

  // arithmetic shift to Q.24 and range check
  always_comb begin
    rnd  = total[W_TERM-1:RND_SHIFT];
    fits = (&rnd[W_RND-1:W_OUT-1]) || !(|rnd[W_RND-1:W_OUT-1]);
  end

  // stage 12: clip and register the result
  always_ff @(posedge clk) begin
    if (en.ld_out) begin
      sat <= !fits;
      if (fits) begin
        stress <= rnd[W_OUT-1:0];
      end else if (rnd[W_RND-1]) begin
        stress <= STRESS_MIN;
      end else begin
        stress <= STRESS_MAX;
      end
    end
  end

endmodule

`default_nettype wire

// ----- verif/neo_hookean_piola_stress_tb.sv -----
// self-checking testbench for the neo-hookean first piola stress pipeline
`timescale 1ns / 1ps

module neo_hookean_piola_stress_tb;
  import nhps_pkg::*;

  localparam int          RESET_CYCLES = 12;
  localparam int          STALL_LIMIT  = 4000;
  localparam int          RAND_GRADS   = 1075;
  localparam int          N_REGS       = 4;
  localparam logic [31:0] ONE_Q24      = 32'h0100_0000;
  localparam logic [31:0] DEF_MAX      = 32'h7FFF_FFFF;
  localparam logic [31:0] DEF_MIN      = 32'h8000_0000;
  localparam mod_t        MOD_MAX      = '1;

  typedef logic signed [255:0]     wide_t;
  typedef logic [8:0][W_IN-1:0]    grad_t;
  typedef enum logic [1:0] {ACT_GRAD, ACT_WRITE, ACT_HOLD} act_kind_t;

  typedef struct packed {
    act_kind_t             kind;
    grad_t                 g;
    logic [W_CFG_IDX-1:0]  idx;
    logic [W_CFG_DATA-1:0] data;
  } act_t;

  typedef struct packed {
    logic [8:0][W_OUT-1:0] p;
    logic                  sat;
  } stress_set_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  in_valid = 1'b0;
  logic                  in_ready;
  def_t                  def_00 = '0, def_10 = '0, def_20 = '0;
  def_t                  def_01 = '0, def_11 = '0, def_21 = '0;
  def_t                  def_02 = '0, def_12 = '0, def_22 = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  stress_t               stress_00, stress_10, stress_20;
  stress_t               stress_01, stress_11, stress_21;
  stress_t               stress_02, stress_12, stress_22;
  logic                  saturated;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [W_CFG_IDX-1:0]  cfg_index = '0;
  logic [W_CFG_DATA-1:0] cfg_data = '0;

  neo_hookean_piola_stress dut (.*);

  // pending stimulus and the stress results still owed by the block
  act_t        grad_backlog [$];
  stress_set_t stress_due [$];

  // shadow copy of the registers
  mod_t   lam_q, mu_q;
  alpha_t alpha_q;
  logic   mixed_q;

  int unsigned grads_taken = 0, stresses_seen = 0, writes_done = 0;
  int unsigned mixed_grads = 0, clipped_seen = 0, errors = 0, idle_cycles = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  // gap length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // exact stress: cofactor columns scaled by fac plus mu times the gradient
  function automatic stress_set_t piola_stress(input grad_t g);
    wide_t       col [3][3];
    wide_t       cof [3][3];
    wide_t       lam_w, mu_w, det, fac, term, rnd;
    stress_set_t res;
    int          a, b;
    res.sat = 1'b0;
    for (int c = 0; c < 3; c++)
      for (int r = 0; r < 3; r++)
        col[c][r] = wide_t'($signed(g[c*3+r]));
    for (int c = 0; c < 3; c++) begin
      a = (c + 1) % 3;
      b = (c + 2) % 3;
      cof[c][0] = col[a][1] * col[b][2] - col[a][2] * col[b][1];
      cof[c][1] = col[a][2] * col[b][0] - col[a][0] * col[b][2];
      cof[c][2] = col[a][0] * col[b][1] - col[a][1] * col[b][0];
    end
    lam_w = wide_t'({208'd0, lam_q});
    mu_w  = wide_t'({208'd0, mu_q});
    if (mixed_q) begin
      fac = -(mu_w <<< 72);
    end else begin
      det = col[0][0] * cof[0][0] + col[0][1] * cof[0][1] + col[0][2] * cof[0][2];
      fac = lam_w * (det - (wide_t'({225'd0, alpha_q}) <<< 48));
    end
    // round half up to Q.24, then clip to 64 bits
    for (int i = 0; i < 9; i++) begin
      term = fac * cof[i/3][i%3] + (mu_w <<< 96) * col[i/3][i%3];
      rnd  = (term + (wide_t'(1) <<< 111)) >>> 112;
      if (rnd == wide_t'($signed(rnd[63:0]))) begin
        res.p[i] = rnd[63:0];
      end else begin
        res.p[i] = rnd[255] ? STRESS_MIN : STRESS_MAX;
        res.sat  = 1'b1;
      end
    end
    return res;
  endfunction

  function automatic grad_t uniform_grad(input logic [31:0] d, input logic [31:0] o);
    grad_t g;
    for (int i = 0; i < 9; i++) g[i] = (i % 4 == 0) ? d : o;
    return g;
  endfunction

  // half near-identity gradients, the rest wide or extreme ones
  function automatic grad_t random_grad();
    grad_t       g;
    int unsigned shape;
    shape = $urandom_range(0, 9);
    for (int i = 0; i < 9; i++) begin
      case (shape)
        0, 1, 2, 3, 4:
          g[i] = ((i % 4 == 0) ? ONE_Q24 : 32'd0) + ($urandom & 32'h007F_FFFF) - 32'h0040_0000;
        5, 6: g[i] = ($urandom & 32'h07FF_FFFF) - 32'h0400_0000;
        7, 8: g[i] = $urandom;
        default: begin
          case ($urandom_range(0, 5))
            0: g[i] = 32'd0;
            1: g[i] = DEF_MAX;
            2: g[i] = DEF_MIN;
            3: g[i] = ONE_Q24;
            4: g[i] = -ONE_Q24;
            default: g[i] = $urandom;
          endcase
        end
      endcase
    end
    return g;
  endfunction

  function automatic mod_t pick_modulus();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return MOD_MAX;
      5: return mod_t'({$urandom, $urandom});
      default: return mod_t'($urandom_range(0, 32'h00FF_FFFF));
    endcase
  endfunction

  // alpha value, sometimes with junk above the register width
  function automatic logic [W_CFG_DATA-1:0] pick_alpha_data();
    alpha_t a;
    case ($urandom_range(0, 5))
      0: a = '0;
      1: a = '1;
      5: a = alpha_t'($urandom);
      default: a = alpha_t'(ONE_Q24 + $urandom_range(0, 32'h00FF_FFFF));
    endcase
    return {($urandom_range(0, 1) != 0) ? 17'($urandom) : 17'd0, a};
  endfunction

  task automatic queue_grad(input grad_t g);
    act_t a;
    a = '0;
    a.kind = ACT_GRAD;
    a.g = g;
    grad_backlog.push_back(a);
  endtask

  task automatic queue_write(input logic [W_CFG_IDX-1:0] idx, input logic [W_CFG_DATA-1:0] data);
    act_t a;
    a = '0;
    a.kind = ACT_WRITE;
    a.idx = idx;
    a.data = data;
    grad_backlog.push_back(a);
  endtask

  task automatic queue_hold();
    act_t a;
    a = '0;
    a.kind = ACT_HOLD;
    grad_backlog.push_back(a);
  endtask

  // sender: one beat from the backlog at a time, writes only once drained
  grad_t       cur_grad;
  act_t        next_act;
  logic        in_fire, cfg_fire, in_busy, cfg_busy, drained, steady;
  int unsigned send_gap;

  always @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      cfg_valid <= 1'b0;
      lam_q     = '0;
      mu_q      = '0;
      alpha_q   = alpha_t'(ONE_Q24);
      mixed_q   = 1'b0;
      send_gap  = 0;
      steady    = 1'b0;
    end else begin
      in_fire  = in_valid && in_ready;
      cfg_fire = cfg_valid && cfg_ready;
      in_busy  = in_valid && !in_ready;
      cfg_busy = cfg_valid && !cfg_ready;
      if (in_fire) begin
        stress_due.push_back(piola_stress(cur_grad));
        grads_taken <= grads_taken + 1;
        if (mixed_q) mixed_grads <= mixed_grads + 1;
      end
      // register write lands in the shadow copy
      if (cfg_fire) begin
        case (cfg_index)
          CFG_LAMBDA: lam_q = cfg_data;
          CFG_MU:     mu_q = cfg_data;
          CFG_ALPHA:  alpha_q = cfg_data[W_ALPHA-1:0];
          CFG_MIXED:  mixed_q = cfg_data[0];
          default: ;
        endcase
        writes_done <= writes_done + 1;
      end
      // pick up the next backlog entry
      if (!in_busy && !cfg_busy) begin
        if (send_gap != 0) begin
          send_gap = send_gap - 1;
        end else if (grad_backlog.size() != 0) begin
          next_act = grad_backlog[0];
          drained  = !in_fire && grads_taken == stresses_seen;
          case (next_act.kind)
            ACT_GRAD: begin
              def_00 <= next_act.g[0];
              def_10 <= next_act.g[1];
              def_20 <= next_act.g[2];
              def_01 <= next_act.g[3];
              def_11 <= next_act.g[4];
              def_21 <= next_act.g[5];
              def_02 <= next_act.g[6];
              def_12 <= next_act.g[7];
              def_22 <= next_act.g[8];
              cur_grad = next_act.g;
              in_busy  = 1'b1;
              void'(grad_backlog.pop_front());
              if ($urandom_range(0, 49) == 0) steady = !steady;
              send_gap = steady ? 0 : pick_gap();
            end
            ACT_WRITE: begin
              if (drained) begin
                cfg_index <= next_act.idx;
                cfg_data  <= next_act.data;
                cfg_busy  = 1'b1;
                void'(grad_backlog.pop_front());
              end
            end
            default: begin
              if (drained) void'(grad_backlog.pop_front());
            end
          endcase
        end
      end
      in_valid  <= in_busy;
      cfg_valid <= cfg_busy;
    end
  end

  // receiver: check each stress beat against the oldest prediction
  stress_set_t got, want;
  logic        take_rdy, open_run;
  int unsigned take_stall;

  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      take_stall = 0;
      open_run   = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got.p = {stress_22, stress_12, stress_02, stress_21, stress_11, stress_01,
                 stress_20, stress_10, stress_00};
        got.sat = saturated;
        stresses_seen <= stresses_seen + 1;
        if (got.sat === 1'b1) clipped_seen <= clipped_seen + 1;
        if (stress_due.size() == 0) begin
          $display("%0t: stress beat with none expected, expected nothing actual %h", $time, got);
          errors++;
        end else begin
          want = stress_due.pop_front();
          for (int i = 0; i < 9; i++)
            if (got.p[i] !== want.p[i]) begin
              $display("%0t: stress_%0d%0d expected %h actual %h",
                       $time, i % 3, i / 3, want.p[i], got.p[i]);
              errors++;
            end
          if (got.sat !== want.sat) begin
            $display("%0t: saturated expected %b actual %b", $time, want.sat, got.sat);
            errors++;
          end
        end
      end
      // random back-pressure with calm stretches
      if (take_stall != 0) begin
        take_stall = take_stall - 1;
        take_rdy   = 1'b0;
      end else begin
        take_rdy = 1'b1;
        if ($urandom_range(0, 49) == 0) open_run = !open_run;
        if (!open_run && $urandom_range(0, 3) == 0) take_stall = pick_gap();
      end
      out_ready <= take_rdy;
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("%0t: no beat for %0d cycles, %0d stress results outstanding",
               $time, STALL_LIMIT, stress_due.size());
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    grad_t                 g;
    logic [W_CFG_DATA-1:0] junk;
    int unsigned           queued, n, hold_at, settings;
    queued   = 0;
    settings = 1;

    // reset settings: both moduli zero, so every stress is zero
    queue_grad(uniform_grad(ONE_Q24, 32'd0));
    queue_grad(random_grad());

    // moderate material, lambda 2.0, mu 1.0, alpha 1.5
    queue_write(CFG_LAMBDA, 48'h0_0002_0000);
    queue_write(CFG_MU, 48'h0_0001_0000);
    queue_write(CFG_ALPHA, 48'h0_0180_0000);
    queue_write(CFG_MIXED, 48'd0);
    queue_grad(uniform_grad(ONE_Q24, 32'd0));
    queue_grad(uniform_grad(32'd0, 32'd0));
    queue_grad(uniform_grad(DEF_MAX, DEF_MAX));
    queue_grad(uniform_grad(DEF_MIN, DEF_MIN));
    queue_grad(uniform_grad(ONE_Q24, ONE_Q24));
    queue_grad(uniform_grad(ONE_Q24 << 1, 32'd0));
    queue_grad(uniform_grad(DEF_MAX, DEF_MIN));
    queue_grad(random_grad());
    settings++;

    // halfway ties: shear term only, smallest mu
    queue_write(CFG_LAMBDA, 48'd0);
    queue_write(CFG_MU, 48'd1);
    for (int i = 0; i < 9; i++)
      case (i % 4)
        0: g[i] = 32'h0000_8000;
        1: g[i] = 32'hFFFF_8000;
        2: g[i] = 32'h0001_8000;
        default: g[i] = 32'hFFFE_8000;
      endcase
    queue_grad(g);
    queue_grad(uniform_grad(32'h0000_7FFF, 32'hFFFF_7FFF));
    settings++;

    // mixed form with junk above bit 0, largest mu: clipping of both signs
    queue_write(CFG_MIXED, 48'hFFFF_0000_0001);
    queue_write(CFG_MU, MOD_MAX);
    queue_grad(uniform_grad(DEF_MAX, DEF_MAX));
    queue_grad(uniform_grad(DEF_MIN, DEF_MIN));
    queue_grad(uniform_grad(ONE_Q24, 32'd0));
    for (int i = 0; i < 9; i++) g[i] = (i % 2 != 0) ? DEF_MIN : DEF_MAX;
    queue_grad(g);
    settings++;

    // largest lambda, alpha zero through a junk bit, writes past the last register
    queue_write(CFG_MIXED, 48'hFFFF_FFFF_FFFE);
    queue_write(CFG_MU, 48'd0);
    queue_write(CFG_LAMBDA, MOD_MAX);
    queue_write(CFG_ALPHA, 48'h0000_8000_0000);
    for (int k = 0; k < N_REGS; k++) queue_write(W_CFG_IDX'(N_REGS + k), 48'hFFFF_FFFF_FFFF);
    queue_grad(uniform_grad(ONE_Q24, 32'd0));
    queue_grad(uniform_grad(32'h7F00_0000, 32'd0));
    g = uniform_grad(32'h7F00_0000, 32'd0);
    g[0] = 32'h8100_0000;
    queue_grad(g);
    queue_write(CFG_ALPHA, 48'h0000_7FFF_FFFF);
    queue_grad(uniform_grad(ONE_Q24, 32'd0));
    settings++;

    // random settings, each with a mid-phase pause until all stress is back
    while (queued < RAND_GRADS) begin
      queue_write(CFG_LAMBDA, pick_modulus());
      queue_write(CFG_MU, pick_modulus());
      queue_write(CFG_ALPHA, pick_alpha_data());
      junk = W_CFG_DATA'({$urandom, $urandom});
      if ($urandom_range(0, 1) != 0) junk[W_CFG_DATA-1:1] = '0;
      junk[0] = ($urandom_range(0, 2) == 0);
      queue_write(CFG_MIXED, junk);
      if ($urandom_range(0, 3) == 0)
        queue_write(W_CFG_IDX'(N_REGS + $urandom_range(0, N_REGS - 1)),
                    W_CFG_DATA'({$urandom, $urandom}));
      n       = $urandom_range(80, 150);
      hold_at = $urandom_range(10, n - 10);
      for (int k = 0; k < n; k++) begin
        if (k == hold_at) queue_hold();
        queue_grad(random_grad());
      end
      queued += n;
      settings++;
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // wait for the backlog to empty and every stress beat to come back
    do @(posedge clk);
    while (grad_backlog.size() != 0 || in_valid || cfg_valid || grads_taken != stresses_seen);
    repeat (N_STAGE + 8) @(posedge clk);

    if (stress_due.size() != 0) begin
      $display("%0t: %0d stress results never arrived", $time, stress_due.size());
      errors++;
    end
    $display("%0d gradients under %0d register settings (%0d writes), %0d in mixed form",
             grads_taken, settings, writes_done, mixed_grads);
    $display("%0d stress beats checked, %0d clipped, %0d mismatches",
             stresses_seen, clipped_seen, errors);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
